// File: rtl/core/wbss_pkg.sv
// wbss_pkg: shared constants and types for the wildcard byte signature scanner
// used by the channel interfaces and the scanner top level; no dependencies

package wbss_pkg;

    // fixed field widths
    localparam int DATA_W     = 8;
    localparam int OFFSET_W   = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 6;

    // signature storage: four 64-bit words and one care bit per byte
    localparam int SIG_BYTES      = 32;
    localparam int PATTERN_WORDS  = 4;
    localparam int BYTES_PER_WORD = CFG_DATA_W / DATA_W;

    // defaults for the top-level parameters
    localparam int MAX_PATTERN_BYTES_DEF = 32;
    localparam int MAX_REGION_BYTES_DEF  = 65536;

    // reset value of the length register
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_0   = 3'd0,
        REG_PATTERN_1   = 3'd1,
        REG_PATTERN_2   = 3'd2,
        REG_PATTERN_3   = 3'd3,
        REG_CARE_MASK   = 3'd4,
        REG_PATTERN_LEN = 3'd5
    } t_cfg_reg;

endpackage

// File: rtl/core/wbss_byte_if.sv
// wbss_byte_if: valid/ready channel carrying one region byte per word
// depends on wbss_pkg for the field widths

interface wbss_byte_if;
    logic                         valid;
    logic                         ready;
    logic [wbss_pkg::DATA_W-1:0]  data_byte;
    logic                         region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

// File: rtl/core/wbss_result_if.sv
// wbss_result_if: valid/ready channel carrying one scan result per word
// depends on wbss_pkg for the field widths

interface wbss_result_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [wbss_pkg::OFFSET_W-1:0]  match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// File: rtl/core/wildcard_byte_signature_scan.sv
// wildcard_byte_signature_scan: masked byte signature search over a byte stream
// depends on wbss_pkg, wbss_byte_if and wbss_result_if

// Takes one region byte per cycle and compares the latest bytes against a signature of
// up to 32 positions, each either compared or a wildcard, in parallel on every byte.
// It takes one byte per clock unless stalled, set by the single compare stage between the byte
// register and the result register; a result word, when a byte yields one, is registered from the byte
// register into the result register, and the input stalls only while a result word waits
// untaken with a byte already held behind it. The first complete match in a
// region gives found with its start offset; a region that ends without one gives
// not found. Bytes past the first MAX_REGION_BYTES of a region cannot match.
// The user must write registers only while the scanner is idle; the block itself does not enforce it.

module wildcard_byte_signature_scan #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int MAX_REGION_BYTES  = wbss_pkg::MAX_REGION_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wbss_byte_if.sink                         i_byte_ch,
    wbss_result_if.source                     o_result_ch,
    input  logic                              i_cfg_wr_en,
    input  logic [wbss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DATA_W    = wbss_pkg::DATA_W;
    localparam int LEN_W     = wbss_pkg::LEN_W;
    localparam int CNT_W     = $clog2(MAX_REGION_BYTES + 1);
    localparam int SUM_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int WIN_IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    // configuration registers
    logic [wbss_pkg::CFG_DATA_W-1:0] r_pattern_word [wbss_pkg::PATTERN_WORDS];
    logic [wbss_pkg::SIG_BYTES-1:0]  r_care;
    logic [LEN_W-1:0]                r_len;

    // scan state
    logic [DATA_W-1:0] r_window [MAX_PATTERN_BYTES];
    logic [CNT_W-1:0]  r_count;
    logic              r_matched;

    // input byte register
    logic              r_s0_valid;
    logic [DATA_W-1:0] r_s0_byte;
    logic              r_s0_end;

    // result register
    logic                          r_out_valid;
    logic                          r_out_found;
    logic [wbss_pkg::OFFSET_W-1:0] r_out_offset;

    logic                          stall;
    logic                          s0_go;
    logic                          take;
    logic [LEN_W-1:0]              len_eff;
    logic [CNT_W-1:0]              count_inc;
    logic [SUM_W-1:0]              start_sum;
    logic [DATA_W-1:0]             win_next [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0]  pos_ok;
    logic                          window_match;
    logic                          matched_now;
    logic                          res_valid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wbss_pkg::PATTERN_WORDS; k++) begin
                r_pattern_word[k] <= '0;
            end
            r_care <= '0;
            r_len  <= wbss_pkg::LEN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (wbss_pkg::t_cfg_reg'(i_cfg_index))
                wbss_pkg::REG_PATTERN_0:   r_pattern_word[0] <= i_cfg_data;
                wbss_pkg::REG_PATTERN_1:   r_pattern_word[1] <= i_cfg_data;
                wbss_pkg::REG_PATTERN_2:   r_pattern_word[2] <= i_cfg_data;
                wbss_pkg::REG_PATTERN_3:   r_pattern_word[3] <= i_cfg_data;
                wbss_pkg::REG_CARE_MASK:   r_care <= i_cfg_data[wbss_pkg::SIG_BYTES-1:0];
                wbss_pkg::REG_PATTERN_LEN: r_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the byte stage moves unless a result waits untaken
    assign stall             = r_out_valid && !o_result_ch.ready;
    assign s0_go             = r_s0_valid && !stall;
    assign i_byte_ch.ready   = !r_s0_valid || !stall;

    // input byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_byte_ch.ready) begin
            r_s0_valid <= i_byte_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_ch.ready && i_byte_ch.valid) begin
            r_s0_byte <= i_byte_ch.data_byte;
            r_s0_end  <= i_byte_ch.region_end;
        end
    end

    // length limited to the window depth
    assign len_eff = (int'(r_len) > MAX_PATTERN_BYTES) ? LEN_W'(MAX_PATTERN_BYTES) : r_len;

    // bytes beyond the region limit stay out of the window
    assign take      = s0_go && (r_count < CNT_W'(MAX_REGION_BYTES));
    assign count_inc = r_count + CNT_W'(1);

    // window as it stands once the new byte is shifted in, newest at index 0
    assign win_next[0] = r_s0_byte;
    for (genvar g = 1; g < MAX_PATTERN_BYTES; g++) begin : g_shift
        assign win_next[g] = r_window[g-1];
    end

    // per position compare: pattern byte j meets window entry len-1-j
    for (genvar g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_pos
        logic                 care;
        logic [DATA_W-1:0]    sig;
        logic [LEN_W:0]       idx_full;
        logic [WIN_IDX_W-1:0] idx;

        if (g < wbss_pkg::SIG_BYTES) begin : g_stored
            assign care = r_care[g];
            assign sig  = r_pattern_word[g / wbss_pkg::BYTES_PER_WORD]
                              [(g % wbss_pkg::BYTES_PER_WORD) * DATA_W +: DATA_W];
        end else begin : g_wild
            assign care = 1'b0;
            assign sig  = '0;
        end

        assign idx_full  = {1'b0, len_eff} - (LEN_W + 1)'(g) - (LEN_W + 1)'(1);
        assign idx       = idx_full[WIN_IDX_W-1:0];
        assign pos_ok[g] = ((LEN_W + 1)'(g) >= {1'b0, len_eff}) || !care ||
                           (win_next[idx] == sig);
    end

    assign window_match = &pos_ok;

    // first match in the region, only once the whole signature lies inside it
    // an empty signature always starts at offset zero
    assign matched_now = take && !r_matched && window_match &&
                         (SUM_W'(count_inc) >= SUM_W'(len_eff));
    assign start_sum   = (len_eff == '0) ? '0 : SUM_W'(count_inc) - SUM_W'(len_eff);
    assign res_valid   = matched_now || (r_s0_end && !r_matched);

    // window shift
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_window <= win_next;
        end
    end

    // region count and match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_matched <= 1'b0;
        end else if (s0_go) begin
            if (r_s0_end) begin
                r_count   <= '0;
                r_matched <= 1'b0;
            end else begin
                if (take) begin
                    r_count <= count_inc;
                end
                if (matched_now) begin
                    r_matched <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s0_go) begin
            r_out_valid <= res_valid;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_go && res_valid) begin
            r_out_found  <= matched_now;
            r_out_offset <= matched_now ? wbss_pkg::OFFSET_W'(start_sum) : '0;
        end
    end

    assign o_result_ch.valid        = r_out_valid;
    assign o_result_ch.found        = r_out_found;
    assign o_result_ch.match_offset = r_out_offset;

`ifndef SYNTHESIS
    // a region end always restarts the count and clears the match flag
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_go && r_s0_end) |=> (r_count == '0 && !r_matched))
        else $error("region end did not clear scan state");

    // the count never passes the region limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REGION_BYTES))
        else $error("region count beyond limit");

    // a match can only be flagged after at least one byte of the region
    a_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matched |-> (r_count != '0))
        else $error("match flag set with empty region");

    // a not-found word carries a zero offset
    a_nf_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_offset == '0))
        else $error("not-found word with nonzero offset");

    // a second found in one region is never produced
    a_single_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_go && r_matched) |-> !matched_now)
        else $error("second match reported in a region");
`endif

endmodule
